// ----- rtl/fplrq_pkg.sv -----
// ----------------------------------------------------------------------------
// fplrq_pkg: shared types and constants of the four-level ready queue
// Opcodes, status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fplrq_pkg;

	localparam int LEVELS = 4;
	localparam int LVL_W  = 2;
	localparam int ID_W   = 8;
	localparam int PRIO_W = 3;
	localparam int STAT_W = 3;

	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_DSP = 2'd1,
		OP_REM = 2'd2,
		OP_NOP = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BADPRIO  = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ENQ_CHK,
		S_ENQ_LINK,
		S_DSP_SCAN,
		S_DSP_RD,
		S_DSP_TAKE,
		S_REM_LVL,
		S_REM_RD,
		S_REM_CHK,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CAPTURE,
		CMD_ENQ_CHK,
		CMD_ENQ_LINK,
		CMD_DSP_SCAN,
		CMD_DSP_TAKE,
		CMD_REM_LVL,
		CMD_REM_CHK
	} cmd_t;

	typedef struct packed {
		cmd_t op;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    bad_prio;
		logic    full;
		logic    found;
		logic    yield;
		logic    lvl_nonempty;
		logic    last_lvl;
		logic    hit;
		logic    at_tail;
		logic    out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fplrq_dp.sv -----
// ----------------------------------------------------------------------------
// fplrq_dp: ready queue datapath
// List heads and tails, entry store memories, free index stack, result and
// output registers. Acts on one command from the controller each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fplrq_dp #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  fplrq_pkg::ctl_cmd_t             cmd,
	output fplrq_pkg::dp_stat_t             stat,
	input  wire logic [1:0]                 in_opcode,
	input  wire logic [7:0]                 in_pid,
	input  wire logic [2:0]                 in_prio,
	input  wire logic                       cfg_valid,
	input  wire logic [7:0]                 cfg_data,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [2:0]                      out_status,
	output logic [7:0]                      out_id,
	output logic [1:0]                      out_level
);
	import fplrq_pkg::*;

	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = EW + 1;

	// entry store and free index stack
	logic [ID_W-1:0] id_mem   [MAX_ENTRIES];
	logic [EW-1:0]   next_mem [MAX_ENTRIES];
	logic [EW-1:0]   free_mem [MAX_ENTRIES];
	logic [ID_W-1:0] rd_id_q;
	logic [EW-1:0]   rd_next_q;
	logic [EW-1:0]   free_rd_q;

	opcode_t          op_q;
	logic [ID_W-1:0]  pid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [ID_W-1:0]  idle_q;
	logic [EW-1:0]    head_q [LEVELS];
	logic [EW-1:0]    tail_q [LEVELS];
	logic [LEVELS-1:0] nonempty_q;
	logic [LVL_W-1:0] lowest_q;
	logic [LVL_W-1:0] lvl_q;
	logic [EW-1:0]    cur_q;
	logic [EW-1:0]    prev_q;
	logic             yielded_q;
	logic [CW-1:0]    sp_q;
	logic [CW-1:0]    fresh_q;
	status_t          res_status_q;
	logic [ID_W-1:0]  res_id_q;
	logic [LVL_W-1:0] res_lvl_q;
	logic             out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [ID_W-1:0]  out_id_q;
	logic [LVL_W-1:0] out_level_q;

	logic             found;
	logic [LVL_W-1:0] scan_lvl;
	logic             at_tail;
	logic             at_head;
	logic             yield;
	logic             hit;
	logic             bad_prio;
	logic             full;
	logic             last_lvl;
	logic [EW-1:0]    new_e;
	logic [LVL_W-1:0] prio_lvl;
	logic [CW-1:0]    sp_m1;
	logic             id_we;
	logic             next_we;
	logic [EW-1:0]    next_wa;
	logic [EW-1:0]    next_wd;
	logic             free_we;

	// first non-empty level at or after the scan start
	always_comb begin
		found    = 1'b0;
		scan_lvl = lowest_q;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if ((LVL_W'(i) >= lowest_q) && nonempty_q[i]) begin
				found    = 1'b1;
				scan_lvl = LVL_W'(i);
			end
		end
	end

	assign at_tail  = (cur_q == tail_q[lvl_q]);
	assign at_head  = (cur_q == head_q[lvl_q]);
	assign last_lvl = (lvl_q == LVL_W'(LEVELS - 1));
	assign yield    = !yielded_q && last_lvl && !at_tail && (rd_id_q == idle_q);
	assign hit      = (rd_id_q == pid_q);
	assign bad_prio = (prio_q >= PRIO_W'(LEVELS));
	assign full     = (sp_q == '0) && (fresh_q == CW'(MAX_ENTRIES));
	assign new_e    = (sp_q != '0) ? free_rd_q : fresh_q[EW-1:0];
	assign prio_lvl = prio_q[LVL_W-1:0];
	assign sp_m1    = sp_q - 1'b1;

	always_comb begin
		stat.opcode       = op_q;
		stat.bad_prio     = bad_prio;
		stat.full         = full;
		stat.found        = found;
		stat.yield        = yield;
		stat.lvl_nonempty = nonempty_q[lvl_q];
		stat.last_lvl     = last_lvl;
		stat.hit          = hit;
		stat.at_tail      = at_tail;
		stat.out_busy     = out_valid_q;
	end

	// memory write controls
	always_comb begin
		id_we   = 1'b0;
		next_we = 1'b0;
		next_wa = tail_q[lvl_q];
		next_wd = cur_q;
		free_we = 1'b0;
		unique case (cmd.op)
			CMD_ENQ_LINK: begin
				id_we   = 1'b1;
				next_we = nonempty_q[prio_lvl];
				next_wa = tail_q[prio_lvl];
				next_wd = new_e;
			end
			CMD_DSP_TAKE: begin
				next_we = yield;
				free_we = !yield;
			end
			CMD_REM_CHK: begin
				next_we = hit && !at_head;
				next_wa = prev_q;
				next_wd = rd_next_q;
				free_we = hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[new_e] <= pid_q;
		end
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (free_we) begin
			free_mem[sp_q[EW-1:0]] <= cur_q;
		end
		rd_id_q   <= id_mem[cur_q];
		rd_next_q <= next_mem[cur_q];
		free_rd_q <= free_mem[sp_m1[EW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_NOP;
			pid_q        <= '0;
			prio_q       <= '0;
			idle_q       <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			nonempty_q   <= '0;
			lowest_q     <= '0;
			lvl_q        <= '0;
			cur_q        <= '0;
			prev_q       <= '0;
			yielded_q    <= 1'b0;
			sp_q         <= '0;
			fresh_q      <= '0;
			res_status_q <= ST_OK;
			res_id_q     <= '0;
			res_lvl_q    <= '0;
		end else begin
			if (cfg_valid) begin
				idle_q <= cfg_data;
			end
			unique case (cmd.op)
				CMD_CAPTURE: begin
					op_q         <= opcode_t'(in_opcode);
					pid_q        <= in_pid;
					prio_q       <= in_prio;
					lvl_q        <= '0;
					yielded_q    <= 1'b0;
					res_status_q <= ST_OK;
					res_id_q     <= '0;
					res_lvl_q    <= '0;
				end
				CMD_ENQ_CHK: begin
					if (bad_prio) begin
						res_status_q <= ST_BADPRIO;
					end else if (full) begin
						res_status_q <= ST_FULL;
					end
				end
				CMD_ENQ_LINK: begin
					if (nonempty_q[prio_lvl]) begin
						tail_q[prio_lvl] <= new_e;
					end else begin
						head_q[prio_lvl]     <= new_e;
						tail_q[prio_lvl]     <= new_e;
						nonempty_q[prio_lvl] <= 1'b1;
					end
					if (prio_lvl < lowest_q) begin
						lowest_q <= prio_lvl;
					end
					if (sp_q != '0) begin
						sp_q <= sp_m1;
					end else begin
						fresh_q <= fresh_q + 1'b1;
					end
				end
				CMD_DSP_SCAN: begin
					if (found) begin
						lowest_q <= scan_lvl;
						lvl_q    <= scan_lvl;
						cur_q    <= head_q[scan_lvl];
					end else begin
						lowest_q     <= LVL_W'(LEVELS - 1);
						res_status_q <= ST_EMPTY;
					end
				end
				CMD_DSP_TAKE: begin
					if (yield) begin
						// idle entry goes to the rear, second entry comes next
						tail_q[lvl_q] <= cur_q;
						head_q[lvl_q] <= rd_next_q;
						cur_q         <= rd_next_q;
						yielded_q     <= 1'b1;
					end else begin
						if (at_tail) begin
							nonempty_q[lvl_q] <= 1'b0;
						end else begin
							head_q[lvl_q] <= rd_next_q;
						end
						sp_q      <= sp_q + 1'b1;
						res_id_q  <= rd_id_q;
						res_lvl_q <= lvl_q;
					end
				end
				CMD_REM_LVL: begin
					if (nonempty_q[lvl_q]) begin
						cur_q  <= head_q[lvl_q];
						prev_q <= head_q[lvl_q];
					end else if (last_lvl) begin
						res_status_q <= ST_NOTFOUND;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				CMD_REM_CHK: begin
					if (hit) begin
						if (at_head) begin
							if (at_tail) begin
								nonempty_q[lvl_q] <= 1'b0;
							end else begin
								head_q[lvl_q] <= rd_next_q;
							end
						end else if (at_tail) begin
							tail_q[lvl_q] <= prev_q;
						end
						sp_q <= sp_q + 1'b1;
					end else if (at_tail) begin
						if (last_lvl) begin
							res_status_q <= ST_NOTFOUND;
						end else begin
							lvl_q <= lvl_q + 1'b1;
						end
					end else begin
						prev_q <= cur_q;
						cur_q  <= rd_next_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_level_q  <= res_lvl_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_level  = out_level_q;

endmodule

`default_nettype wire

// ----- rtl/fplrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// fplrq_ctrl: ready queue controller
// Sequences enqueue, dispatch and remove through the datapath, one
// transaction at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fplrq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           out_ready,
	input  fplrq_pkg::dp_stat_t stat,
	output fplrq_pkg::ctl_cmd_t cmd
);
	import fplrq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.opcode)
					OP_ENQ:  state_d = S_ENQ_CHK;
					OP_DSP:  state_d = S_DSP_SCAN;
					OP_REM:  state_d = S_REM_LVL;
					default: state_d = S_DONE;
				endcase
			end
			S_ENQ_CHK:  state_d = (stat.bad_prio || stat.full) ? S_DONE : S_ENQ_LINK;
			S_ENQ_LINK: state_d = S_DONE;
			S_DSP_SCAN: state_d = stat.found ? S_DSP_RD : S_DONE;
			S_DSP_RD:   state_d = S_DSP_TAKE;
			S_DSP_TAKE: state_d = stat.yield ? S_DSP_RD : S_DONE;
			S_REM_LVL: begin
				priority if (stat.lvl_nonempty) begin
					state_d = S_REM_RD;
				end else if (stat.last_lvl) begin
					state_d = S_DONE;
				end else begin
					state_d = S_REM_LVL;
				end
			end
			S_REM_RD:   state_d = S_REM_CHK;
			S_REM_CHK: begin
				priority if (stat.hit) begin
					state_d = S_DONE;
				end else if (stat.at_tail) begin
					state_d = stat.last_lvl ? S_DONE : S_REM_LVL;
				end else begin
					state_d = S_REM_RD;
				end
			end
			S_DONE: begin
				if (!stat.out_busy || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op       = CMD_NONE;
		cmd.load_out = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = CMD_CAPTURE;
				end
			end
			S_ENQ_CHK:  cmd.op = CMD_ENQ_CHK;
			S_ENQ_LINK: cmd.op = CMD_ENQ_LINK;
			S_DSP_SCAN: cmd.op = CMD_DSP_SCAN;
			S_DSP_TAKE: cmd.op = CMD_DSP_TAKE;
			S_REM_LVL:  cmd.op = CMD_REM_LVL;
			S_REM_CHK:  cmd.op = CMD_REM_CHK;
			S_DONE:     cmd.load_out = !stat.out_busy || out_ready;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/four_level_priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// four_level_priority_ready_queue: four-level priority ready queue
// FIFO ready lists of process ids per level in a shared linked entry store,
// with enqueue, dispatch (idle id yields on the last level) and remove.
//
//   channel   direction   handshake              payload
//   in        to block    in_valid / in_ready    opcode, process_id, priority_req
//   out       from block  out_valid / out_ready  status, granted_id, granted_level
//   cfg       to block    cfg_valid / cfg_ready  cfg_data (idle process id)
//
// Remove walks the lists through the store's registered read port, reading and
// then checking each visited entry. One transaction is worked at a time.
// Reset clears all lists; the store needs no clearing pass.
// A stalled result holds in the output register while the next transaction
// is taken; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_priority_ready_queue #(
	parameter int MAX_ENTRIES = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] process_id,
	input  wire logic [2:0] priority_req,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      status,
	output logic [7:0]      granted_id,
	output logic [1:0]      granted_level,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);
	import fplrq_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	fplrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fplrq_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_opcode  (opcode),
		.in_pid     (process_id),
		.in_prio    (priority_req),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_status (status),
		.out_id     (granted_id),
		.out_level  (granted_level)
	);

endmodule

`default_nettype wire

// ----- rtl/fplrq_checker.sv -----
// ----------------------------------------------------------------------------
// fplrq_checker: port-level checks of the ready queue
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fplrq_props (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] status,
	input wire logic [7:0] granted_id,
	input wire logic [1:0] granted_level
);
	import fplrq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(granted_id) && $stable(granted_level))
		else $error("result changed while stalled");

	// only a successful transaction carries a grant
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (granted_id == '0) && (granted_level == '0))
		else $error("grant fields set on a failed transaction");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_FULL))
		else $error("status code out of range");

	// one transaction in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

endmodule

bind four_level_priority_ready_queue fplrq_props u_fplrq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.granted_id    (granted_id),
	.granted_level (granted_level)
);

`default_nettype wire
